FILE: rtl/vogi_pkg.sv
// Shared types, constants and helpers for the voxel occupancy grid inflate core.
package vogi_pkg;

  localparam int unsigned MAX_X = 64;
  localparam int unsigned MAX_Y = 128;
  localparam int unsigned MAX_Z = 64;

  localparam int unsigned MAX_XY  = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
  localparam int unsigned MAX_ALL = (MAX_XY > MAX_Z) ? MAX_XY : MAX_Z;

  localparam int unsigned CX_W   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int unsigned CY_W   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int unsigned CZ_W   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int unsigned IDX_W  = (MAX_ALL > 1) ? $clog2(MAX_ALL) : 1;
  localparam int unsigned ROWS   = MAX_X * MAX_Y;
  localparam int unsigned ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int unsigned POS_W     = 20;
  localparam int unsigned DIFF_W    = POS_W + 1;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned RAD_W     = 4;
  localparam int unsigned EXT_X_W   = 7;
  localparam int unsigned EXT_Y_W   = 8;
  localparam int unsigned EXT_Z_W   = 7;
  localparam int unsigned EXT_CMP_W = 10;
  localparam int unsigned SUM_W     = IDX_W + RAD_W;
  localparam int unsigned STEP_W    = $clog2(POS_W);

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned AXIS_X    = 0;
  localparam int unsigned AXIS_Y    = 1;
  localparam int unsigned AXIS_Z    = 2;

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_VOXEL_SZ  = 3'd3,
    REG_RADIUS    = 3'd4,
    REG_EXTENT_X  = 3'd5,
    REG_EXTENT_Y  = 3'd6,
    REG_EXTENT_Z  = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_PLAN,
    ST_SWEEP,
    ST_DRAIN,
    ST_QREAD,
    ST_QDATA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                    command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    cloud_last;
  } in_req_t;

  typedef struct packed {
    logic            occupied;
    logic            ignored;
    logic [CX_W-1:0] cell_x;
    logic [CY_W-1:0] cell_y;
    logic [CZ_W-1:0] cell_z;
  } out_req_t;

  // highest usable index for an extent register, zero treated as one
  function automatic logic [IDX_W-1:0] ext_top(input logic [EXT_CMP_W-1:0] ext,
                                               input logic [EXT_CMP_W-1:0] maxv);
    logic [EXT_CMP_W-1:0] top;
    priority if (ext == '0) begin
      top = '0;
    end else if (ext > maxv) begin
      top = maxv - 1'b1;
    end else begin
      top = ext - 1'b1;
    end
    return IDX_W'(top);
  endfunction

  function automatic logic [ADDR_W-1:0] row_addr(input logic [IDX_W-1:0] x,
                                                 input logic [IDX_W-1:0] y);
    return ADDR_W'(x) * ADDR_W'(MAX_Y) + ADDR_W'(y);
  endfunction

endpackage

FILE: rtl/voxel_occupancy_grid_inflate_core.sv
// Voxel occupancy grid with obstacle inflation: config, index divider and row memory.
//
// After reset the block runs a clearing pass over the row memory, one row a cycle,
// during which no request is taken. Each request then resolves its voxel index one
// axis after the other on a shared radix-2 divider; an axis whose offset from the
// origin is negative is set to cell zero without a division. A query then reads the
// row of its cell from the memory. An insert sweeps the covered xy rows through the
// single memory with a read-modify-write a cycle, (2r+1)^2 rows at most (121 at
// radius five); a frozen insert writes no row and is flagged as ignored.
// A result waits in an output register while the next request is taken.
module voxel_occupancy_grid_inflate_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  vogi_pkg::in_req_t                  in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output vogi_pkg::out_req_t                 out_req_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vogi_pkg::PADDR_W-1:0]       paddr,
  input  logic [vogi_pkg::PDATA_W-1:0]       pwdata,
  output logic [vogi_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int unsigned IW = vogi_pkg::IDX_W;
  localparam int unsigned PW = vogi_pkg::POS_W;
  localparam int unsigned SW = vogi_pkg::SIZE_W;
  localparam int unsigned NA = vogi_pkg::NUM_AXES;

  // configuration
  logic [PW-1:0]                     org_q [NA];
  logic [SW-1:0]                     vsize_q;
  logic [vogi_pkg::RAD_W-1:0]        radius_q;
  logic [vogi_pkg::EXT_X_W-1:0]      ext_x_q;
  logic [vogi_pkg::EXT_Y_W-1:0]      ext_y_q;
  logic [vogi_pkg::EXT_Z_W-1:0]      ext_z_q;
  logic                              cfg_we;
  vogi_pkg::reg_idx_e                cfg_idx;

  // control
  vogi_pkg::state_e                  state_q, state_d;
  logic [vogi_pkg::ADDR_W-1:0]       clr_q, clr_d;
  logic                              frozen_q, frozen_d;
  logic                              out_valid_q, out_valid_d;
  logic                              wr_pend_q, wr_pend_d;

  // datapath
  vogi_pkg::in_req_t                 req_q, req_d;
  vogi_pkg::out_req_t                out_q, out_d;
  logic [vogi_pkg::AXIS_W-1:0]       axis_q, axis_d;
  logic [vogi_pkg::STEP_W-1:0]       step_q, step_d;
  logic [PW-1:0]                     dq_q, dq_d;
  logic [SW-1:0]                     rem_q, rem_d;
  logic [IW-1:0]                     cell_q [NA];
  logic [IW-1:0]                     cell_d [NA];
  logic [IW-1:0]                     lo_q [NA];
  logic [IW-1:0]                     lo_d [NA];
  logic [IW-1:0]                     hi_q [NA];
  logic [IW-1:0]                     hi_d [NA];
  logic [IW-1:0]                     x_q, x_d;
  logic [IW-1:0]                     y_q, y_d;
  logic [vogi_pkg::ADDR_W-1:0]       waddr_q, waddr_d;
  logic                              occ_q, occ_d;
  logic                              ign_q, ign_d;

  // memory
  logic [vogi_pkg::MAX_Z-1:0]        row_mem [vogi_pkg::ROWS];
  logic [vogi_pkg::MAX_Z-1:0]        rdata_q;
  logic                              mem_we;
  logic [vogi_pkg::ADDR_W-1:0]       mem_waddr;
  logic [vogi_pkg::ADDR_W-1:0]       mem_raddr;
  logic [vogi_pkg::MAX_Z-1:0]        mem_wdata;
  logic [vogi_pkg::MAX_Z-1:0]        zmask;

  // combinational helpers
  logic [IW-1:0]                     emax [NA];
  logic [vogi_pkg::DIFF_W-1:0]       diff;
  logic [SW-1:0]                     s_eff;
  logic [SW:0]                       rem_sh;
  logic                              ge;
  logic [PW-1:0]                     quo;
  logic [IW-1:0]                     q_clamp;
  logic [vogi_pkg::SUM_W-1:0]        c_w, r_w, up_w;
  logic                              axis_last;

  // ------------------------------------------------------------------ config port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = vogi_pkg::reg_idx_e'(paddr[vogi_pkg::PADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      vogi_pkg::REG_ORIGIN_X: prdata = vogi_pkg::PDATA_W'(org_q[vogi_pkg::AXIS_X]);
      vogi_pkg::REG_ORIGIN_Y: prdata = vogi_pkg::PDATA_W'(org_q[vogi_pkg::AXIS_Y]);
      vogi_pkg::REG_ORIGIN_Z: prdata = vogi_pkg::PDATA_W'(org_q[vogi_pkg::AXIS_Z]);
      vogi_pkg::REG_VOXEL_SZ: prdata = vogi_pkg::PDATA_W'(vsize_q);
      vogi_pkg::REG_RADIUS:   prdata = vogi_pkg::PDATA_W'(radius_q);
      vogi_pkg::REG_EXTENT_X: prdata = vogi_pkg::PDATA_W'(ext_x_q);
      vogi_pkg::REG_EXTENT_Y: prdata = vogi_pkg::PDATA_W'(ext_y_q);
      vogi_pkg::REG_EXTENT_Z: prdata = vogi_pkg::PDATA_W'(ext_z_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[vogi_pkg::AXIS_X] <= '0;
      org_q[vogi_pkg::AXIS_Y] <= '0;
      org_q[vogi_pkg::AXIS_Z] <= '0;
      vsize_q                 <= SW'(10);
      radius_q                <= vogi_pkg::RAD_W'(5);
      ext_x_q                 <= vogi_pkg::EXT_X_W'(64);
      ext_y_q                 <= vogi_pkg::EXT_Y_W'(128);
      ext_z_q                 <= vogi_pkg::EXT_Z_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vogi_pkg::REG_ORIGIN_X: org_q[vogi_pkg::AXIS_X] <= pwdata[PW-1:0];
        vogi_pkg::REG_ORIGIN_Y: org_q[vogi_pkg::AXIS_Y] <= pwdata[PW-1:0];
        vogi_pkg::REG_ORIGIN_Z: org_q[vogi_pkg::AXIS_Z] <= pwdata[PW-1:0];
        vogi_pkg::REG_VOXEL_SZ: vsize_q  <= pwdata[SW-1:0];
        vogi_pkg::REG_RADIUS:   radius_q <= pwdata[vogi_pkg::RAD_W-1:0];
        vogi_pkg::REG_EXTENT_X: ext_x_q  <= pwdata[vogi_pkg::EXT_X_W-1:0];
        vogi_pkg::REG_EXTENT_Y: ext_y_q  <= pwdata[vogi_pkg::EXT_Y_W-1:0];
        vogi_pkg::REG_EXTENT_Z: ext_z_q  <= pwdata[vogi_pkg::EXT_Z_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------ helpers
  assign emax[vogi_pkg::AXIS_X] = vogi_pkg::ext_top(vogi_pkg::EXT_CMP_W'(ext_x_q),
                                                    vogi_pkg::EXT_CMP_W'(vogi_pkg::MAX_X));
  assign emax[vogi_pkg::AXIS_Y] = vogi_pkg::ext_top(vogi_pkg::EXT_CMP_W'(ext_y_q),
                                                    vogi_pkg::EXT_CMP_W'(vogi_pkg::MAX_Y));
  assign emax[vogi_pkg::AXIS_Z] = vogi_pkg::ext_top(vogi_pkg::EXT_CMP_W'(ext_z_q),
                                                    vogi_pkg::EXT_CMP_W'(vogi_pkg::MAX_Z));

  assign s_eff = (vsize_q == '0) ? SW'(1) : vsize_q;

  always_comb begin
    unique case (axis_q)
      vogi_pkg::AXIS_W'(vogi_pkg::AXIS_X):
        diff = {req_q.pos_x[PW-1], req_q.pos_x}
             - {org_q[vogi_pkg::AXIS_X][PW-1], org_q[vogi_pkg::AXIS_X]};
      vogi_pkg::AXIS_W'(vogi_pkg::AXIS_Y):
        diff = {req_q.pos_y[PW-1], req_q.pos_y}
             - {org_q[vogi_pkg::AXIS_Y][PW-1], org_q[vogi_pkg::AXIS_Y]};
      default:
        diff = {req_q.pos_z[PW-1], req_q.pos_z}
             - {org_q[vogi_pkg::AXIS_Z][PW-1], org_q[vogi_pkg::AXIS_Z]};
    endcase
  end

  // one restoring division step
  assign rem_sh  = {rem_q, dq_q[PW-1]};
  assign ge      = rem_sh >= {1'b0, s_eff};
  assign quo     = {dq_q[PW-2:0], ge};
  assign q_clamp = (quo > PW'(emax[axis_q])) ? emax[axis_q] : IW'(quo);
  assign axis_last = (axis_q == vogi_pkg::AXIS_W'(vogi_pkg::AXIS_Z));

  always_comb begin
    for (int i = 0; i < vogi_pkg::MAX_Z; i++) begin
      zmask[i] = (IW'(i) >= lo_q[vogi_pkg::AXIS_Z]) && (IW'(i) <= hi_q[vogi_pkg::AXIS_Z]);
    end
  end

  // ------------------------------------------------------------------ control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    frozen_d    = frozen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_pend_d   = 1'b0;
    req_d       = req_q;
    out_d       = out_q;
    axis_d      = axis_q;
    step_d      = step_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    x_d         = x_q;
    y_d         = y_q;
    waddr_d     = waddr_q;
    occ_d       = occ_q;
    ign_d       = ign_q;
    mem_raddr   = vogi_pkg::row_addr(cell_q[vogi_pkg::AXIS_X], cell_q[vogi_pkg::AXIS_Y]);
    c_w         = '0;
    r_w         = vogi_pkg::SUM_W'(radius_q);
    up_w        = '0;
    for (int a = 0; a < NA; a++) begin
      cell_d[a] = cell_q[a];
      lo_d[a]   = lo_q[a];
      hi_d[a]   = hi_q[a];
    end
    in_ready_o  = 1'b0;

    unique case (state_q)
      vogi_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == vogi_pkg::ADDR_W'(vogi_pkg::ROWS - 1)) begin
          state_d = vogi_pkg::ST_IDLE;
        end
      end
      vogi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_req_i;
          axis_d  = '0;
          state_d = vogi_pkg::ST_LOAD;
        end
      end
      vogi_pkg::ST_LOAD: begin
        if (diff[vogi_pkg::DIFF_W-1]) begin
          cell_d[axis_q] = '0;
          axis_d         = axis_q + 1'b1;
          state_d        = axis_last ? vogi_pkg::ST_PLAN : vogi_pkg::ST_LOAD;
        end else begin
          dq_d    = diff[PW-1:0];
          rem_d   = '0;
          step_d  = '0;
          state_d = vogi_pkg::ST_DIV;
        end
      end
      vogi_pkg::ST_DIV: begin
        dq_d   = quo;
        rem_d  = ge ? SW'(rem_sh - {1'b0, s_eff}) : rem_sh[SW-1:0];
        step_d = step_q + 1'b1;
        if (step_q == vogi_pkg::STEP_W'(PW - 1)) begin
          cell_d[axis_q] = q_clamp;
          axis_d         = axis_q + 1'b1;
          state_d        = axis_last ? vogi_pkg::ST_PLAN : vogi_pkg::ST_LOAD;
        end
      end
      vogi_pkg::ST_PLAN: begin
        for (int a = 0; a < NA; a++) begin
          c_w     = vogi_pkg::SUM_W'(cell_q[a]);
          up_w    = c_w + r_w;
          lo_d[a] = (c_w > r_w) ? IW'(c_w - r_w) : '0;
          hi_d[a] = (up_w > vogi_pkg::SUM_W'(emax[a])) ? emax[a] : IW'(up_w);
        end
        occ_d = 1'b0;
        ign_d = 1'b0;
        priority if (req_q.command == vogi_pkg::CMD_QUERY) begin
          state_d = vogi_pkg::ST_QREAD;
        end else if (frozen_q) begin
          ign_d   = 1'b1;
          state_d = vogi_pkg::ST_FINISH;
        end else begin
          x_d     = lo_d[vogi_pkg::AXIS_X];
          y_d     = lo_d[vogi_pkg::AXIS_Y];
          state_d = vogi_pkg::ST_SWEEP;
        end
      end
      vogi_pkg::ST_SWEEP: begin
        mem_raddr = vogi_pkg::row_addr(x_q, y_q);
        wr_pend_d = 1'b1;
        waddr_d   = mem_raddr;
        if (y_q == hi_q[vogi_pkg::AXIS_Y]) begin
          y_d = lo_q[vogi_pkg::AXIS_Y];
          if (x_q == hi_q[vogi_pkg::AXIS_X]) begin
            state_d = vogi_pkg::ST_DRAIN;
          end else begin
            x_d = x_q + 1'b1;
          end
        end else begin
          y_d = y_q + 1'b1;
        end
      end
      vogi_pkg::ST_DRAIN: begin
        frozen_d = frozen_q | req_q.cloud_last;
        state_d  = vogi_pkg::ST_FINISH;
      end
      vogi_pkg::ST_QREAD: begin
        state_d = vogi_pkg::ST_QDATA;
      end
      vogi_pkg::ST_QDATA: begin
        occ_d   = rdata_q[cell_q[vogi_pkg::AXIS_Z][vogi_pkg::CZ_W-1:0]];
        state_d = vogi_pkg::ST_FINISH;
      end
      vogi_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.occupied = occ_q;
          out_d.ignored  = ign_q;
          out_d.cell_x   = vogi_pkg::CX_W'(cell_q[vogi_pkg::AXIS_X]);
          out_d.cell_y   = vogi_pkg::CY_W'(cell_q[vogi_pkg::AXIS_Y]);
          out_d.cell_z   = vogi_pkg::CZ_W'(cell_q[vogi_pkg::AXIS_Z]);
          out_valid_d    = 1'b1;
          state_d        = vogi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vogi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vogi_pkg::ST_CLEAR;
      clr_q       <= '0;
      frozen_q    <= 1'b0;
      out_valid_q <= 1'b0;
      wr_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      frozen_q    <= frozen_d;
      out_valid_q <= out_valid_d;
      wr_pend_q   <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    out_q   <= out_d;
    axis_q  <= axis_d;
    step_q  <= step_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    x_q     <= x_d;
    y_q     <= y_d;
    waddr_q <= waddr_d;
    occ_q   <= occ_d;
    ign_q   <= ign_d;
    for (int a = 0; a < NA; a++) begin
      cell_q[a] <= cell_d[a];
      lo_q[a]   <= lo_d[a];
      hi_q[a]   <= hi_d[a];
    end
  end

  // ------------------------------------------------------------------ row memory
  // read in the cycle before its write; rows within one sweep never repeat
  assign mem_we    = (state_q == vogi_pkg::ST_CLEAR) || wr_pend_q;
  assign mem_waddr = (state_q == vogi_pkg::ST_CLEAR) ? clr_q : waddr_q;
  assign mem_wdata = (state_q == vogi_pkg::ST_CLEAR) ? '0 : (rdata_q | zmask);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= row_mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: rtl/voxel_occupancy_grid_inflate_core_chk.sv
// Port-level checker for the voxel occupancy grid inflate core, bound to the top level.
module voxel_occupancy_grid_inflate_core_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input vogi_pkg::in_req_t            in_req_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input vogi_pkg::out_req_t           out_req_o
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // one request in work and one result waiting at most; no result without a request
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd3) && (!out_valid_o || pend_q != 2'd0))
    else $error("results out of step with requests");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request taken while another is in work");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_req_o.occupied && out_req_o.ignored))
    else $error("occupied and ignored both set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

endmodule

bind voxel_occupancy_grid_inflate_core voxel_occupancy_grid_inflate_core_chk u_chk (.*);
